/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the radar packet deframer.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RPDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define RPDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rpdm_pkg.sv */
// Shared types and constants of the radar packet deframer and magnitude core.
// No dependencies; used by every module of the block.
package rpdm_pkg;

  localparam int QUEUE_DEPTH_LOG2 = 2;
  localparam int QUEUE_DEPTH      = 1 << QUEUE_DEPTH_LOG2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_MERGE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ANGLE = 2'd1;
  localparam logic [15:0] MAX_ANGLE_RESET = 16'd1999;

  localparam int HEADER_LEN = 16;
  localparam int ENTRY_LEN  = 12;
  localparam int FIRST_ENTRY_END = HEADER_LEN + ENTRY_LEN - 1;
  localparam logic [31:0] POS_LEN_END   = 32'd3;
  localparam logic [31:0] POS_ANGLE_END = 32'd13;
  localparam logic [31:0] POS_COUNT_END = 32'd15;
  localparam logic [3:0]  OFS_DIST_END  = 4'd3;
  localparam logic [3:0]  OFS_RE_END    = 4'd7;
  localparam logic [3:0]  OFS_IM_END    = 4'd11;

  localparam logic [31:0] FLT_MAX_BITS = 32'h7F7F_FFFF;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_STOP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    JOB_ENTRY   = 2'd0,
    JOB_SUMMARY = 2'd1,
    JOB_STOP    = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        clear;
    logic        sum_after;
    logic [31:0] distance;
    logic [31:0] re;
    logic [31:0] im;
    logic [15:0] angle;
    logic        short_pkt;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] distance;
    logic [31:0] intensity;
    logic [15:0] angle;
    logic [15:0] kept;
    logic        short_pkt;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MAG  = 2'd1,
    B_PLAN = 2'd2,
    B_EMIT = 2'd3
  } back_state_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_SQA   = 3'd1,
    M_SQB   = 3'd2,
    M_ALIGN = 3'd3,
    M_SQRT  = 3'd4,
    M_ROUND = 3'd5
  } mag_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] wa;
    logic [31:0] wb;
  } mag_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } mag_rsp_t;

endpackage

/* src/rpdm_front.sv */
// Front end: byte parser of the packet stream, turns bytes into jobs.
// Depends on rpdm_pkg; feeds rpdm_job_queue.
module rpdm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte,
  input  logic            stream_start,
  input  logic [15:0]     max_angle,
  input  logic            q_full,
  output logic            q_push,
  output rpdm_pkg::job_t  q_job
);
  import rpdm_pkg::*;

  logic [31:0] pos, pos_next;
  logic [31:0] dlen, dlen_next;
  logic [31:0] fasm, fasm_next;
  logic [15:0] cnt, cnt_next;
  logic [15:0] ang, ang_next;
  logic [31:0] ent_d, ent_d_next;
  logic [31:0] re, re_next;
  logic [15:0] k, k_next;
  logic [3:0]  ofs, ofs_next;
  logic        shrt, shrt_next;
  logic        halted, halted_next;
  logic        pend_clr, pend_clr_next;
  logic        accept;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_comb begin : parse
    logic        stop;
    logic [33:0] need;
    pos_next      = pos;
    dlen_next     = dlen;
    fasm_next     = fasm;
    cnt_next      = cnt;
    ang_next      = ang;
    ent_d_next    = ent_d;
    re_next       = re;
    k_next        = k;
    ofs_next      = ofs;
    shrt_next     = shrt;
    halted_next   = halted;
    pend_clr_next = pend_clr;
    q_push        = 1'b0;
    q_job         = '0;
    stop          = 1'b0;
    need          = '0;
    if (accept) begin
      if (stream_start) begin
        pos_next      = '0;
        dlen_next     = '0;
        fasm_next     = '0;
        cnt_next      = '0;
        ang_next      = '0;
        ent_d_next    = '0;
        re_next       = '0;
        k_next        = '0;
        ofs_next      = '0;
        shrt_next     = 1'b0;
        halted_next   = 1'b0;
        pend_clr_next = 1'b1;
      end
      if (!halted_next) begin
        fasm_next = {data_byte, fasm_next[31:8]};
        if (pos_next == POS_LEN_END) begin
          dlen_next = (fasm_next < 32'(HEADER_LEN)) ? 32'(HEADER_LEN) : fasm_next;
        end else if (pos_next == POS_ANGLE_END) begin
          ang_next = fasm_next[31:16];
          if (ang_next > max_angle) begin
            stop        = 1'b1;
            halted_next = 1'b1;
            q_push      = 1'b1;
            q_job.kind  = JOB_STOP;
            q_job.angle = ang_next;
          end
        end else if (pos_next == POS_COUNT_END) begin
          cnt_next  = fasm_next[31:16];
          need      = 34'(cnt_next) * 34'(ENTRY_LEN) + 34'(HEADER_LEN);
          shrt_next = need > {2'b00, dlen_next};
          k_next    = '0;
          ofs_next  = '0;
          // no entry fits or none declared: summary right away
          if (cnt_next == 16'd0 || dlen_next <= 32'(FIRST_ENTRY_END)) begin
            q_push          = 1'b1;
            q_job.kind      = JOB_SUMMARY;
            q_job.angle     = ang_next;
            q_job.short_pkt = shrt_next;
          end
        end else if (pos_next > POS_COUNT_END && k_next < cnt_next) begin
          if (ofs_next == OFS_DIST_END) begin
            ent_d_next = fasm_next;
          end else if (ofs_next == OFS_RE_END) begin
            re_next = fasm_next;
          end else if (ofs_next == OFS_IM_END) begin
            q_push          = 1'b1;
            q_job.kind      = JOB_ENTRY;
            q_job.distance  = ent_d_next;
            q_job.re        = re_next;
            q_job.im        = fasm_next;
            q_job.angle     = ang_next;
            q_job.short_pkt = shrt_next;
            // last entry declared, or the next one would not fit
            q_job.sum_after = (17'(k_next) + 17'd1 == 17'(cnt_next)) ||
                              (33'(pos_next) + 33'(ENTRY_LEN) >= 33'(dlen_next));
            k_next          = k_next + 16'd1;
          end
          ofs_next = (ofs_next == OFS_IM_END) ? 4'd0 : ofs_next + 4'd1;
        end
        if (!stop) begin
          if (pos_next >= POS_COUNT_END && 33'(pos_next) + 33'd1 >= 33'(dlen_next)) begin
            pos_next  = '0;
            shrt_next = 1'b0;
            cnt_next  = '0;
            k_next    = '0;
          end else begin
            pos_next = pos_next + 32'd1;
          end
        end
      end
      if (q_push) begin
        q_job.clear   = pend_clr_next;
        pend_clr_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      dlen     <= '0;
      fasm     <= '0;
      cnt      <= '0;
      ang      <= '0;
      ent_d    <= '0;
      re       <= '0;
      k        <= '0;
      ofs      <= '0;
      shrt     <= 1'b0;
      halted   <= 1'b0;
      pend_clr <= 1'b0;
    end else begin
      pos      <= pos_next;
      dlen     <= dlen_next;
      fasm     <= fasm_next;
      cnt      <= cnt_next;
      ang      <= ang_next;
      ent_d    <= ent_d_next;
      re       <= re_next;
      k        <= k_next;
      ofs      <= ofs_next;
      shrt     <= shrt_next;
      halted   <= halted_next;
      pend_clr <= pend_clr_next;
    end
  end

endmodule

/* src/rpdm_job_queue.sv */
// Short job queue between the parser and the back end.
// Depends on rpdm_pkg for job_t and the queue depth.
module rpdm_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpdm_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output rpdm_pkg::job_t dout,
  output logic           empty
);
  import rpdm_pkg::*;

  job_t                      mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH_LOG2-1:0] wp, rp;
  logic [QUEUE_DEPTH_LOG2:0]   count;

  assign full  = count == (QUEUE_DEPTH_LOG2+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      count <= count + (QUEUE_DEPTH_LOG2+1)'(push && !full)
                     - (QUEUE_DEPTH_LOG2+1)'(pop && !empty);
    end
  end

endmodule

/* src/rpdm_mag.sv */
// Float32 magnitude sqrt(a*a+b*b), round to nearest even, iterative root.
// Depends on rpdm_pkg; one shared 24x24 squarer, one root bit per cycle.
module rpdm_mag (
  input  logic               clk,
  input  logic               rst,
  input  rpdm_pkg::mag_req_t req,
  output rpdm_pkg::mag_rsp_t rsp
);
  import rpdm_pkg::*;

  mag_state_t  state, state_next;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic [47:0] asq, bsq;
  logic [63:0] s;
  logic [34:0] rem;
  logic [31:0] root;
  logic [4:0]  iter;
  logic        sticky;
  logic [31:0] value;
  logic        done;

  logic [23:0] ua_m, ub_m;
  logic [7:0]  ua_e, ub_e;
  logic        swap, both_zero;
  logic [23:0] sq_op;
  logic [47:0] prod;
  logic [63:0] s_al;
  logic        st_al;
  logic [34:0] rem_sh, trial;
  logic [31:0] rnd_value;

  assign rsp.done  = done;
  assign rsp.value = value;

  always_comb begin
    ua_m = (req.wa[30:23] == 8'd0) ? 24'd0 :
           (req.wa[30:23] == 8'hFF) ? 24'hFF_FFFF : {1'b1, req.wa[22:0]};
    ua_e = (req.wa[30:23] == 8'hFF) ? 8'd254 : req.wa[30:23];
    ub_m = (req.wb[30:23] == 8'd0) ? 24'd0 :
           (req.wb[30:23] == 8'hFF) ? 24'hFF_FFFF : {1'b1, req.wb[22:0]};
    ub_e = (req.wb[30:23] == 8'hFF) ? 8'd254 : req.wb[30:23];
    swap      = (ua_m == 24'd0) || (ub_m != 24'd0 && ub_e > ua_e);
    both_zero = (ua_m == 24'd0) && (ub_m == 24'd0);
  end

  assign sq_op = (state == M_SQA) ? ma : mb;
  assign prod  = 48'(sq_op) * 48'(sq_op);

  // Line up the smaller square under the larger one.
  always_comb begin : align
    logic [8:0] d;
    logic [8:0] kk;
    logic [63:0] a_sh;
    d     = {ea - eb, 1'b0};
    kk    = d - 9'd14;
    a_sh  = {2'b00, asq, 14'd0};
    s_al  = a_sh;
    st_al = 1'b0;
    if (mb != 24'd0) begin
      if (d <= 9'd14) begin
        s_al = a_sh + ({16'd0, bsq} << 4'(9'd14 - d));
      end else if (kk >= 9'd48) begin
        st_al = 1'b1;
      end else begin
        st_al = |(bsq & ((48'd1 << kk[5:0]) - 48'd1));
        s_al  = a_sh + 64'(bsq >> kk[5:0]);
      end
    end
  end

  assign rem_sh = {rem[32:0], s[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  // Root lies in [2^30, 2^32): only two normalisation cases.
  always_comb begin : round
    logic [23:0] mant0, mant;
    logic [7:0]  rbits, half;
    logic [3:0]  sh;
    logic        up;
    logic [24:0] m25;
    logic [9:0]  biased;
    if (root[31]) begin
      mant0 = root[31:8];
      rbits = root[7:0];
      half  = 8'h80;
      sh    = 4'd8;
    end else begin
      mant0 = root[30:7];
      rbits = {1'b0, root[6:0]};
      half  = 8'h40;
      sh    = 4'd7;
    end
    up  = (rbits > half) ||
          (rbits == half && (sticky || rem != '0 || mant0[0]));
    m25 = {1'b0, mant0} + 25'(up);
    if (m25[24]) begin
      mant = m25[24:1];
      sh   = sh + 4'd1;
    end else begin
      mant = m25[23:0];
    end
    biased = 10'(sh) + 10'(ea) - 10'd7;
    if (biased >= 10'd255) rnd_value = FLT_MAX_BITS;
    else                   rnd_value = {1'b0, biased[7:0], mant[22:0]};
  end

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE:  if (req.start && !both_zero) state_next = M_SQA;
      M_SQA:   state_next = M_SQB;
      M_SQB:   state_next = M_ALIGN;
      M_ALIGN: state_next = M_SQRT;
      M_SQRT:  if (iter == 5'd31) state_next = M_ROUND;
      M_ROUND: state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= M_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == M_ROUND) || (state == M_IDLE && req.start && both_zero);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          ma    <= swap ? ub_m : ua_m;
          ea    <= swap ? ub_e : ua_e;
          mb    <= swap ? ua_m : ub_m;
          eb    <= swap ? ua_e : ub_e;
          value <= '0;
        end
      end
      M_SQA: asq <= prod;
      M_SQB: bsq <= prod;
      M_ALIGN: begin
        s      <= s_al;
        sticky <= st_al;
        rem    <= '0;
        root   <= '0;
        iter   <= '0;
      end
      M_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        s    <= {s[61:0], 2'b00};
        iter <= iter + 5'd1;
      end
      M_ROUND: value <= rnd_value;
      default: ;
    endcase
  end

endmodule

/* src/rpdm_back.sv */
// Back end: magnitude, equal-distance merge, summaries and the result queue.
// Depends on rpdm_pkg and rpdm_mag; takes jobs from rpdm_job_queue.
module rpdm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              merge_en,
  input  logic              q_empty,
  output logic              q_pop,
  input  rpdm_pkg::job_t    q_job,
  output logic              empty,
  input  logic              pop,
  output rpdm_pkg::result_t res
);
  import rpdm_pkg::*;

  back_state_t state, state_next;
  job_t        job, job_next;
  logic [31:0] held_d, held_d_next;
  logic [31:0] held_i, held_i_next;
  logic        held_v, held_v_next;
  logic [15:0] emitted, emitted_next;
  result_t     slot [3];
  result_t     slot_next [3];
  logic [2:0]  slot_v, slot_v_next;

  result_t                     omem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH_LOG2-1:0] owp, orp;
  logic [QUEUE_DEPTH_LOG2:0]   ocount;
  logic                        ofull, owr;
  result_t                     odata;

  mag_req_t mreq;
  mag_rsp_t mrsp;

  rpdm_mag u_mag (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign mreq.start = (state == B_IDLE) && !q_empty && (q_job.kind == JOB_ENTRY);
  assign mreq.wa    = q_job.re;
  assign mreq.wb    = q_job.im;

  assign ofull = ocount == (QUEUE_DEPTH_LOG2+1)'(QUEUE_DEPTH);
  assign empty = ocount == '0;
  assign res   = omem[orp];

  always_comb begin : control
    logic [15:0] n_ent;
    logic [1:0]  pick;
    result_t     er;
    state_next   = state;
    job_next     = job;
    held_d_next  = held_d;
    held_i_next  = held_i;
    held_v_next  = held_v;
    emitted_next = emitted;
    slot_next    = slot;
    slot_v_next  = slot_v;
    q_pop        = 1'b0;
    owr          = 1'b0;
    odata        = '0;
    n_ent        = '0;
    pick         = 2'd0;
    er           = '0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_next = q_job;
          if (q_job.clear) begin
            held_v_next  = 1'b0;
            emitted_next = '0;
          end
          state_next = (q_job.kind == JOB_ENTRY) ? B_MAG : B_PLAN;
        end
      end
      B_MAG: begin
        if (mrsp.done) state_next = B_PLAN;
      end
      B_PLAN: begin
        slot_v_next = '0;
        slot_next[0] = '0;
        slot_next[1] = '0;
        slot_next[2] = '0;
        er.kind = KIND_ENTRY;
        if (job.kind == JOB_ENTRY) begin
          if (merge_en) begin
            if (held_v && held_d == job.distance) begin
              if (mrsp.value > held_i) held_i_next = mrsp.value;
            end else begin
              if (held_v) begin
                slot_v_next[0] = 1'b1;
                slot_next[0]   = er;
                slot_next[0].distance  = held_d;
                slot_next[0].intensity = held_i;
              end
              held_d_next = job.distance;
              held_i_next = mrsp.value;
              held_v_next = 1'b1;
            end
          end else begin
            if (held_v) begin
              slot_v_next[0] = 1'b1;
              slot_next[0]   = er;
              slot_next[0].distance  = held_d;
              slot_next[0].intensity = held_i;
              held_v_next    = 1'b0;
            end
            slot_v_next[1] = 1'b1;
            slot_next[1]   = er;
            slot_next[1].distance  = job.distance;
            slot_next[1].intensity = mrsp.value;
          end
          if (job.sum_after) begin
            // flush what is held ahead of the summary
            if (held_v_next) begin
              slot_v_next[1] = 1'b1;
              slot_next[1]   = er;
              slot_next[1].distance  = held_d_next;
              slot_next[1].intensity = held_i_next;
              held_v_next    = 1'b0;
            end
            n_ent = emitted + 16'(slot_v_next[0]) + 16'(slot_v_next[1]);
            slot_v_next[2]         = 1'b1;
            slot_next[2].kind      = KIND_SUMMARY;
            slot_next[2].angle     = job.angle;
            slot_next[2].kept      = n_ent;
            slot_next[2].short_pkt = job.short_pkt;
            emitted_next           = '0;
          end else begin
            emitted_next = emitted + 16'(slot_v_next[0]) + 16'(slot_v_next[1]);
          end
        end else if (job.kind == JOB_SUMMARY) begin
          slot_v_next[2]         = 1'b1;
          slot_next[2].kind      = KIND_SUMMARY;
          slot_next[2].angle     = job.angle;
          slot_next[2].short_pkt = job.short_pkt;
          held_v_next            = 1'b0;
          emitted_next           = '0;
        end else begin
          slot_v_next[2]     = 1'b1;
          slot_next[2].kind  = KIND_STOP;
          slot_next[2].angle = job.angle;
        end
        state_next = (slot_v_next == 3'b000) ? B_IDLE : B_EMIT;
      end
      B_EMIT: begin
        pick = slot_v[0] ? 2'd0 : (slot_v[1] ? 2'd1 : 2'd2);
        if (!ofull) begin
          owr               = 1'b1;
          slot_v_next[pick] = 1'b0;
          odata             = slot[pick];
          odata.last        = (slot_v_next == 3'b000);
          if (slot_v_next == 3'b000) state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      held_v  <= 1'b0;
      emitted <= '0;
      slot_v  <= '0;
      held_d  <= '0;
      held_i  <= '0;
    end else begin
      state   <= state_next;
      held_v  <= held_v_next;
      emitted <= emitted_next;
      slot_v  <= slot_v_next;
      held_d  <= held_d_next;
      held_i  <= held_i_next;
    end
  end

  always_ff @(posedge clk) begin
    job  <= job_next;
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (owr) omem[owp] <= odata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= '0;
      orp    <= '0;
      ocount <= '0;
    end else begin
      if (owr) owp <= owp + 1'b1;
      if (pop && !empty) orp <= orp + 1'b1;
      ocount <= ocount + (QUEUE_DEPTH_LOG2+1)'(owr)
                       - (QUEUE_DEPTH_LOG2+1)'(pop && !empty);
    end
  end

endmodule

/* src/radar_packet_deframer_magnitude_core.sv */
// Radar packet deframer with float32 magnitude. Bytes go in one per cycle
// while the four-job queue between parser and back end has room; the parser
// turns each complete entry into one job. The back end takes one job at a
// time; for an entry it runs two squarings on one shared 24x24 multiplier, an
// alignment step, the bit-per-cycle square root and rounding, then writes the
// results into a four-deep result queue, waiting while that queue is full.
// Full rises whenever the job queue fills. No clearing pass follows reset.
// Depends on rpdm_pkg, rpdm_front, rpdm_job_queue, rpdm_back, assert_macros.svh.
`include "assert_macros.svh"

module radar_packet_deframer_magnitude_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte,
  input  logic                           stream_start,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     kind,
  output logic signed [31:0]             distance,
  output logic [31:0]                    intensity_bits,
  output logic [15:0]                    angle,
  output logic [15:0]                    kept_count,
  output logic                           short_packet,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rpdm_pkg::*;

  logic        merge_en;
  logic [15:0] max_angle;
  logic        q_push, q_full, q_pop, q_empty;
  job_t        q_in, q_out;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_en  <= 1'b0;
      max_angle <= MAX_ANGLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MERGE:     merge_en  <= cfg_data[0];
        CFG_MAX_ANGLE: max_angle <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rpdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .stream_start (stream_start),
    .max_angle    (max_angle),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_in)
  );

  rpdm_job_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  rpdm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .merge_en (merge_en),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_job    (q_out),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign kind           = res.kind;
  assign distance       = res.distance;
  assign intensity_bits = res.intensity;
  assign angle          = res.angle;
  assign kept_count     = res.kept;
  assign short_packet   = res.short_pkt;
  assign last           = res.last;

  `RPDM_ASSERT_IMP(a_job_no_overflow, q_push, !q_full, "job pushed into a full queue")
  `RPDM_ASSERT_IMP(a_summary_last, !empty && kind == KIND_SUMMARY, last, "summary not last")
  `RPDM_ASSERT_IMP(a_stop_last, !empty && kind == KIND_STOP, last && kept_count == 16'd0,
                   "stop result malformed")
  `RPDM_ASSERT_IMP(a_entry_clean, !empty && kind == KIND_ENTRY,
                   angle == 16'd0 && kept_count == 16'd0 && !short_packet,
                   "entry result carries summary fields")
  `RPDM_ASSERT_NXT(a_accept_full_stall, push && !full && q_push && q_pop == 1'b0 && q_empty,
                   !q_empty, "accepted job lost")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for radar_packet_deframer_magnitude_core.
// Depends on rpdm_pkg and the core RTL; a scoreboard class predicts every result byte by byte.
`timescale 1ns / 100ps

module testbench;
  import rpdm_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    kind_t       kind;
    logic [31:0] ent_dist;
    logic [31:0] inten;
    logic [15:0] ang;
    logic [15:0] kept;
    logic        shrt;
    logic        lst;
  } deframe_result_t;

  class deframer_scoreboard_t;
    bit          merge_on;
    int unsigned angle_limit;
    int unsigned byte_pos, decl_len, assembly, ent_total, pkt_angle;
    longint unsigned dist_re;
    int unsigned hold_dist, hold_mag, kept_cnt;
    bit          hold_ok, stopped, short_seen;
    deframe_result_t awaited[$];
    deframe_result_t step_q[$];
    int          errors;
    int          produced;

    function new();
      merge_on = 0;
      angle_limit = MAX_ANGLE_RESET;
      errors = 0;
      produced = 0;
      clear_state();
    endfunction

    function void clear_state();
      byte_pos = 0; decl_len = 0; assembly = 0; ent_total = 0; pkt_angle = 0;
      dist_re = 0; hold_dist = 0; hold_mag = 0; hold_ok = 0; kept_cnt = 0;
      stopped = 0; short_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MERGE) merge_on = val[0];
      else if (idx == CFG_MAX_ANGLE) angle_limit = val;
    endfunction

    function void split_float(logic [31:0] w, output longint unsigned m, output int e);
      if (w[30:23] == 8'd0) begin
        m = 0; e = 0;
      end else if (w[30:23] == 8'hFF) begin
        m = 64'hFF_FFFF; e = 254;
      end else begin
        m = {40'd0, 1'b1, w[22:0]}; e = w[30:23];
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s -= res + bitv;
          res = (res >> 1) + bitv;
        end else res >>= 1;
        bitv >>= 2;
      end
      return res;
    endfunction

    // Correctly rounded float32 sqrt(a*a + b*b)
    function logic [31:0] cplx_magnitude(logic [31:0] wa, logic [31:0] wb);
      longint unsigned ma, mb, tm, s, bsq, r, mant, rem, half;
      int ea, eb, te, d, n, sh, biased;
      bit sticky;
      sticky = 0;
      split_float(wa, ma, ea);
      split_float(wb, mb, eb);
      if (ma == 0 && mb == 0) return 32'd0;
      if (ma == 0 || (mb != 0 && eb > ea)) begin
        tm = ma; te = ea; ma = mb; ea = eb; mb = tm; eb = te;
      end
      s = (ma * ma) << 14;
      if (mb != 0) begin
        bsq = mb * mb;
        d = 2 * (ea - eb);
        if (d <= 14) s += bsq << (14 - d);
        else if (d - 14 >= 64) sticky = 1;
        else begin
          if ((bsq & ((64'd1 << (d - 14)) - 1)) != 0) sticky = 1;
          s += bsq >> (d - 14);
        end
      end
      r = int_sqrt(s);
      if (r * r != s) sticky = 1;
      n = 0;
      while (n < 64 && (r >> n) != 0) n++;
      sh = n - 24;
      mant = r >> sh;
      rem = r & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && (sticky || mant[0]))) begin
        mant++;
        if (mant == (64'd1 << 24)) begin
          mant >>= 1;
          sh++;
        end
      end
      biased = sh + ea - 7;
      if (biased <= 0) return 32'd0;
      if (biased >= 255) return FLT_MAX_BITS;
      return {biased[8:0], mant[22:0]};
    endfunction

    function void add(kind_t k, logic [31:0] dv, logic [31:0] iv, logic [15:0] av,
                      logic [15:0] kv, logic sv);
      deframe_result_t res;
      res.kind = k; res.ent_dist = dv; res.inten = iv; res.ang = av;
      res.kept = kv; res.shrt = sv; res.lst = 1'b0;
      step_q.push_back(res);
    endfunction

    function void add_entry(logic [31:0] dv, logic [31:0] iv);
      add(KIND_ENTRY, dv, iv, 16'd0, 16'd0, 1'b0);
      kept_cnt = (kept_cnt + 1) & 16'hFFFF;
    endfunction

    function void add_summary();
      if (hold_ok) begin
        add_entry(hold_dist, hold_mag);
        hold_ok = 0;
      end
      add(KIND_SUMMARY, 0, 0, 16'(pkt_angle), 16'(kept_cnt), short_seen);
    endfunction

    // Note one accepted input transaction and queue what it causes
    function void note_byte(logic [7:0] b, logic start);
      int unsigned pos, cnt, avail, off, dv, mv;
      step_q.delete();
      if (start) clear_state();
      if (stopped) return;
      pos = byte_pos;
      assembly = (assembly >> 8) | (int'(b) << 24);
      if (pos == POS_LEN_END) begin
        decl_len = (assembly < HEADER_LEN) ? HEADER_LEN : assembly;
      end else if (pos == POS_ANGLE_END) begin
        pkt_angle = assembly >> 16;
        if (pkt_angle > angle_limit) begin
          add(KIND_STOP, 0, 0, 16'(pkt_angle), 16'd0, 1'b0);
          stopped = 1;
          finish_step();
          return;
        end
      end else if (pos == POS_COUNT_END) begin
        cnt = assembly >> 16;
        avail = (decl_len - HEADER_LEN) / ENTRY_LEN;
        ent_total = (cnt < avail) ? cnt : avail;
        short_seen = ent_total < cnt;
        hold_ok = 0;
        kept_cnt = 0;
        if (ent_total == 0) add_summary();
      end else if (pos >= HEADER_LEN &&
                   longint'(pos) < HEADER_LEN + ENTRY_LEN * longint'(ent_total)) begin
        off = pos - HEADER_LEN;
        if (off % ENTRY_LEN == OFS_DIST_END) begin
          dist_re[31:0] = assembly;
        end else if (off % ENTRY_LEN == OFS_RE_END) begin
          dist_re[63:32] = assembly;
        end else if (off % ENTRY_LEN == OFS_IM_END) begin
          dv = dist_re[31:0];
          mv = cplx_magnitude(dist_re[63:32], assembly);
          if (merge_on) begin
            if (hold_ok && hold_dist == dv) begin
              if (mv > hold_mag) hold_mag = mv;
            end else begin
              if (hold_ok) add_entry(hold_dist, hold_mag);
              hold_dist = dv;
              hold_mag = mv;
              hold_ok = 1;
            end
          end else begin
            if (hold_ok) begin
              add_entry(hold_dist, hold_mag);
              hold_ok = 0;
            end
            add_entry(dv, mv);
          end
          if (off / ENTRY_LEN + 1 == ent_total) add_summary();
        end
      end
      if (pos >= POS_COUNT_END && pos + 1 >= decl_len) begin
        byte_pos = 0; hold_ok = 0; kept_cnt = 0; short_seen = 0; ent_total = 0;
      end else byte_pos = pos + 1;
      finish_step();
    endfunction

    function void finish_step();
      if (step_q.size() == 0) return;
      step_q[step_q.size()-1].lst = 1'b1;
      foreach (step_q[i]) awaited.push_back(step_q[i]);
      produced += step_q.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [1:0] k, logic [31:0] dv, logic [31:0] iv, logic [15:0] av,
                      logic [15:0] kv, logic sv, logic lv);
      deframe_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result kind %0d", k));
        return;
      end
      e = awaited.pop_front();
      if (k !== e.kind) report($sformatf("kind %0d, want %0d", k, e.kind));
      if (dv !== e.ent_dist) report($sformatf("distance %h, want %h", dv, e.ent_dist));
      if (iv !== e.inten) report($sformatf("intensity %h, want %h", iv, e.inten));
      if (av !== e.ang) report($sformatf("angle %0d, want %0d", av, e.ang));
      if (kv !== e.kept) report($sformatf("kept_count %0d, want %0d", kv, e.kept));
      if (sv !== e.shrt) report($sformatf("short_packet %b, want %b", sv, e.shrt));
      if (lv !== e.lst) report($sformatf("last %b, want %b", lv, e.lst));
    endtask
  endclass

  logic clk, rst;
  logic push, full, stream_start, empty, pop;
  logic [7:0] data_byte;
  logic [1:0] kind;
  logic signed [31:0] distance;
  logic [31:0] intensity_bits;
  logic [15:0] angle, kept_count;
  logic short_packet, last;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  deframer_scoreboard_t sb;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 14;
  int unsigned pop_idle_pct = 14;
  int unsigned pop_hold = 0;
  int unsigned bytes_sent = 0;
  logic [7:0] pkt_q[$];
  logic [31:0] ent_d[$], ent_re[$], ent_im[$];

  radar_packet_deframer_magnitude_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .stream_start(stream_start), .empty(empty), .pop(pop), .kind(kind),
    .distance(distance), .intensity_bits(intensity_bits), .angle(angle),
    .kept_count(kept_count), .short_packet(short_packet), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random pops, plus a long hold-off when requested
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result(kind, distance, intensity_bits, angle, kept_count, short_packet, last);
  end

  task put_byte(logic [7:0] b, logic st);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    stream_start <= st;
    do @(posedge clk); while (full);
    sb.note_byte(b, st);
    bytes_sent++;
  endtask

  task send_range(int from, int upto, logic start_first);
    for (int i = from; i < upto && i < pkt_q.size(); i++)
      put_byte(pkt_q[i], start_first && i == 0);
    @(negedge clk);
    push <= 1'b0;
  endtask

  task drain();
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function void add_le(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) pkt_q.push_back(v[8*i +: 8]);
  endfunction

  // Header, then the queued entries, then filler or a cut to total bytes
  function void build_packet(logic [31:0] len, logic [15:0] cnt, logic [15:0] ang, int total);
    pkt_q.delete();
    add_le(len, 4);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le(ang, 2);
    add_le(cnt, 2);
    foreach (ent_d[i]) begin
      add_le(ent_d[i], 4);
      add_le(ent_re[i], 4);
      add_le(ent_im[i], 4);
    end
    while (pkt_q.size() < total) pkt_q.push_back(8'($urandom_range(255)));
    while (pkt_q.size() > total) void'(pkt_q.pop_back());
    ent_d.delete(); ent_re.delete(); ent_im.delete();
  endfunction

  function logic [31:0] rand_float(int unsigned base_exp);
    logic [7:0] ex;
    logic [22:0] man;
    case ($urandom_range(9))
      0: ex = 8'd0;
      1: ex = 8'hFF;
      2: ex = 8'd1;
      3: ex = 8'hFE;
      4, 5, 6: ex = 8'(base_exp + $urandom_range(20) - 10);
      default: ex = 8'($urandom_range(1, 254));
    endcase
    case ($urandom_range(7))
      0: man = '0;
      1: man = '1;
      default: man = 23'($urandom);
    endcase
    return {1'($urandom_range(1)), ex, man};
  endfunction

  function void add_ent(logic [31:0] d, logic [31:0] re, logic [31:0] im);
    ent_d.push_back(d); ent_re.push_back(re); ent_im.push_back(im);
  endfunction

  task directed_part();
    // length below the header, no entries: summary on the count byte
    build_packet(32'd0, 16'd0, 16'd5, 16);
    send_range(0, 16, 1'b1);
    // zero, subnormal, infinity and extreme distances
    add_ent(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    add_ent(32'h7FFF_FFFF, 32'h7F80_0000, 32'h3F80_0000);
    add_ent(32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
    add_ent(32'd0, 32'h0080_0000, 32'h8080_0000);
    add_ent(32'd7, 32'h4040_0000, 32'hC080_0000);
    build_packet(32'd76, 16'd5, 16'd1999, 76);
    send_range(0, 76, 1'b0);
    // short packet: three declared, one fits, then part of the second entry
    add_ent(32'd3, 32'h3F80_0000, 32'h3F80_0000);
    add_ent(32'd4, 32'h3F80_0000, 32'h0);
    build_packet(32'd33, 16'd3, 16'd0, 33);
    send_range(0, 33, 1'b0);
    // no entries but a long packet: summary, then skip the rest
    build_packet(32'd40, 16'd0, 16'd9, 40);
    send_range(0, 40, 1'b0);
    // angle above the limit halts; trailing bytes are ignored
    build_packet(32'd16, 16'd0, 16'd2000, 22);
    send_range(0, 22, 1'b0);
    write_reg(CFG_MERGE, 16'd1);
    add_ent(32'd10, 32'h3F80_0000, 32'h0);
    add_ent(32'd10, 32'h4000_0000, 32'h0);
    add_ent(32'd10, 32'h3F00_0000, 32'h0);
    add_ent(32'd11, 32'h3F80_0000, 32'h3F80_0000);
    add_ent(32'd10, 32'h0, 32'h0);
    build_packet(32'd76, 16'd5, 16'd100, 76);
    send_range(0, 76, 1'b1);
    // switch merge off with an entry held part-way through a packet
    add_ent(32'd20, 32'h3F80_0000, 32'h0);
    add_ent(32'd21, 32'h3F80_0000, 32'h0);
    build_packet(32'd40, 16'd2, 16'd1, 40);
    send_range(0, 28, 1'b0);
    write_reg(CFG_MERGE, 16'd0);
    for (int i = 28; i < 40; i++) put_byte(pkt_q[i], 1'b0);
    @(negedge clk);
    push <= 1'b0;
    write_reg(CFG_MAX_ANGLE, 16'd0);
    build_packet(32'd16, 16'd0, 16'd0, 16);
    send_range(0, 16, 1'b0);
    build_packet(32'd16, 16'd0, 16'd1, 16);
    send_range(0, 16, 1'b0);
    write_reg(CFG_MAX_ANGLE, 16'hFFFF);
    build_packet(32'd16, 16'd0, 16'hFFFF, 16);
    send_range(0, 16, 1'b1);
  endtask

  task random_packet(bit needs_start, output bit leaves_dirty);
    int unsigned n, len, total, ang, base_exp, dsel;
    bit st;
    st = needs_start || ($urandom_range(3) == 0);
    leaves_dirty = 0;
    if ($urandom_range(9) == 0) begin
      // noise: arbitrary bytes, parser state unknown afterwards
      n = $urandom_range(5, 30);
      pkt_q.delete();
      repeat (n) pkt_q.push_back(8'($urandom_range(255)));
      send_range(0, n, st);
      leaves_dirty = 1;
      return;
    end
    n = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
    base_exp = $urandom_range(20, 235);
    dsel = $urandom;
    for (int i = 0; i < n; i++)
      add_ent(($urandom_range(2) == 0) ? $urandom : dsel + $urandom_range(1),
              rand_float(base_exp), rand_float(base_exp));
    len = HEADER_LEN + ENTRY_LEN * n;
    case ($urandom_range(9))
      0: len = $urandom_range(15);
      1: if (n > 0) len = len - $urandom_range(1, 12 * n);
      2, 3: len = len + $urandom_range(1, 8);
      default: ;
    endcase
    total = (len < HEADER_LEN) ? HEADER_LEN : len;
    ang = ($urandom_range(11) == 0) ? $urandom_range(65535) : $urandom_range(sb.angle_limit);
    build_packet(len, 16'(n), 16'(ang), total);
    send_range(0, total, st);
    leaves_dirty = ang > sb.angle_limit;
  endtask

  initial begin
    bit dirty;
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    stream_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_part();

    dirty = 1;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_MERGE, 16'(phase[0]));
      write_reg(CFG_MAX_ANGLE,
                16'((phase == 3) ? $urandom_range(65535) : 1999 + phase * 20000));
      send_idle_pct = (phase == 1) ? 0 : 14;
      pop_idle_pct = (phase == 1) ? 0 : 14;
      if (phase == 2) pop_hold = 600;
      dirty = 1;
      // keep offering bytes until the phase's byte target is met and, in phase 2, the result side stops holding off
      while (bytes_sent < 340 + 30 * (phase + 1) || (phase == 2 && pop_hold > 0))
        random_packet(dirty, dirty);
    end

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/rpdm_pkg.sv
src/rpdm_front.sv
src/rpdm_job_queue.sv
src/rpdm_mag.sv
src/rpdm_back.sv
src/radar_packet_deframer_magnitude_core.sv
tb/testbench.sv
